// ===== hdl/spqm_pkg.sv =====
package spqm_pkg;

   localparam int CMD_W    = 2;
   localparam int PORT_W   = 3;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int ID_W     = 8;

   typedef enum logic [CMD_W-1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_FLUSH   = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_POOL_EMPTY  = 2'd1,
      STAT_BAD_PORT    = 2'd2,
      STAT_QUEUE_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ENQ,
      ST_DEQ,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [PORT_W-1:0] port;
      logic              insert_at_head;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     packet_id;
   } rsp_type;

endpackage

// ===== hdl/spqm_ram.sv =====
module spqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of one entry in a cycle returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/shared_pool_port_queue_manager_unit.sv =====
// channel   ports                              word
// --------  ---------------------------------  ------------------------------------
// request   req_valid, req_ready, req_data     command, port, insert_at_head
// response  rsp_valid, rsp_ready, rsp_data     status, slot, packet_id
//
// steps: enqueue and dequeue read the link memory, then write back; errors, unused
//   commands and a flush of an empty queue pass through a done state; a flush walks its n slots
// the link memory has a single read port: a flush walk reads one link per cycle
// reset clears all control state at once; no clearing pass, the per-slot written bits
//   stand in for the reset contents of both memories
// a new request is taken while an earlier response word still waits; the last cycle
//   of a command stalls with no side effects until the response register is free
module shared_pool_port_queue_manager_unit import spqm_pkg::*; #(
   parameter int POOL_SLOTS = 16,
   parameter int PORT_COUNT = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_AW = $clog2(POOL_SLOTS);
   localparam int LINK_W  = $clog2(POOL_SLOTS + 1);
   localparam int PORT_AW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
   localparam int CNT_W   = LINK_W;
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_SLOTS);

   function automatic logic link_ok(input logic [LINK_W-1:0] l);
      return l < LINK_NULL;
   endfunction

   // control and pointer registers
   state_type            state_ff, state_in;
   logic [LINK_W-1:0]    free_head_ff, free_head_in;
   logic [LINK_W-1:0]    head_ff [PORT_COUNT];
   logic [LINK_W-1:0]    head_in [PORT_COUNT];
   logic [LINK_W-1:0]    tail_ff [PORT_COUNT];
   logic [LINK_W-1:0]    tail_in [PORT_COUNT];
   logic [ID_W-1:0]      seq_ff  [PORT_COUNT];
   logic [ID_W-1:0]      seq_in  [PORT_COUNT];
   logic [POOL_SLOTS-1:0] vld_ff, vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // per-command working registers
   logic [PORT_AW-1:0]   port_ff, port_in;
   logic                 at_head_ff, at_head_in;
   logic [SLOT_AW-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   rsp_type              res_ff, res_in;
   logic [SLOT_AW-1:0]   rd_addr_ff, rd_addr_in;
   logic                 rd_vld_ff, rd_vld_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // memory ports
   logic                 rd_en;
   logic                 link_we;
   logic [SLOT_AW-1:0]   link_waddr;
   logic [LINK_W-1:0]    link_wdata;
   logic [LINK_W-1:0]    link_q;
   logic                 id_we;
   logic [ID_W-1:0]      id_wdata;
   logic [ID_W-1:0]      id_q;

   // decode and datapath helpers
   logic                 out_free;
   logic                 fin;
   rsp_type              fin_rsp;
   logic                 cmd_known;
   logic                 bad_port;
   logic [PORT_AW-1:0]   req_pidx;
   logic [LINK_W-1:0]    req_head;
   logic [LINK_W-1:0]    req_tail;
   logic [LINK_W-1:0]    cur_head;
   logic [LINK_W-1:0]    cur_tail;
   logic [LINK_W-1:0]    link_rd;
   logic [ID_W-1:0]      id_rd;
   logic [ID_W-1:0]      seq_nx;
   logic                 q_empty;
   logic [CNT_W-1:0]     cnt_nx;
   logic                 more;

   spqm_ram #(.WIDTH(LINK_W), .DEPTH(POOL_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_in),
      .rd_data (link_q)
   );

   // id writes always go to the slot under work
   spqm_ram #(.WIDTH(ID_W), .DEPTH(POOL_SLOTS)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (cur_ff),
      .wr_data (id_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_in),
      .rd_data (id_q)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cmd_known = (req_data.command == CMD_ENQUEUE) || (req_data.command == CMD_DEQUEUE) ||
                      (req_data.command == CMD_FLUSH);
   assign bad_port  = {1'b0, req_data.port} >= 4'(PORT_COUNT);
   assign req_pidx  = req_data.port[PORT_AW-1:0];
   assign req_head  = head_ff[req_pidx];
   assign req_tail  = tail_ff[req_pidx];
   assign cur_head  = head_ff[port_ff];
   assign cur_tail  = tail_ff[port_ff];

   // a slot never written still holds its reset contents: chained to the next, id zero
   assign link_rd = rd_vld_ff ? link_q : (LINK_W'(rd_addr_ff) + LINK_W'(1));
   assign id_rd   = rd_vld_ff ? id_q : '0;

   assign q_empty = !(link_ok(cur_head) && link_ok(cur_tail));
   assign cnt_nx  = cnt_ff + CNT_W'(1);
   assign more    = link_ok(link_rd) && (cnt_nx < CNT_W'(POOL_SLOTS));

   always_comb begin
      seq_nx = seq_ff[port_ff] + ID_W'(1);
      if (seq_nx == '0) begin
         seq_nx = ID_W'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      free_head_in = free_head_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      seq_in       = seq_ff;
      vld_in       = vld_ff;
      port_in      = port_ff;
      at_head_in   = at_head_ff;
      cur_in       = cur_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rd_addr_in   = rd_addr_ff;
      rd_en        = 1'b0;
      link_we      = 1'b0;
      link_waddr   = cur_ff;
      link_wdata   = free_head_ff;
      id_we        = 1'b0;
      id_wdata     = '0;
      fin          = 1'b0;
      fin_rsp      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               port_in    = req_pidx;
               at_head_in = req_data.insert_at_head;
               res_in     = '0;
               state_in   = ST_DONE;
               if (!cmd_known) begin
                  // unused command code: plain ok word, nothing changes
                  res_in.status = STAT_OK;
               end else if (bad_port) begin
                  res_in.status = STAT_BAD_PORT;
               end else begin
                  unique case (req_data.command)
                     CMD_ENQUEUE: begin
                        if (!link_ok(free_head_ff)) begin
                           res_in.status = STAT_POOL_EMPTY;
                        end else begin
                           rd_en      = 1'b1;
                           rd_addr_in = free_head_ff[SLOT_AW-1:0];
                           cur_in     = free_head_ff[SLOT_AW-1:0];
                           state_in   = ST_ENQ;
                           // tail link written now, leaves the write port free next cycle
                           if (link_ok(req_head) && link_ok(req_tail) &&
                               !req_data.insert_at_head) begin
                              link_we    = 1'b1;
                              link_waddr = req_tail[SLOT_AW-1:0];
                              link_wdata = free_head_ff;
                           end
                        end
                     end
                     CMD_DEQUEUE: begin
                        if (!link_ok(req_head)) begin
                           res_in.status = STAT_QUEUE_EMPTY;
                        end else begin
                           rd_en      = 1'b1;
                           rd_addr_in = req_head[SLOT_AW-1:0];
                           cur_in     = req_head[SLOT_AW-1:0];
                           state_in   = ST_DEQ;
                        end
                     end
                     CMD_FLUSH: begin
                        if (link_ok(req_head)) begin
                           rd_en      = 1'b1;
                           rd_addr_in = req_head[SLOT_AW-1:0];
                           cur_in     = req_head[SLOT_AW-1:0];
                           cnt_in     = '0;
                           state_in   = ST_FLUSH;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end

         ST_ENQ: begin
            if (out_free) begin
               fin          = 1'b1;
               link_we      = 1'b1;
               link_waddr   = cur_ff;
               link_wdata   = (q_empty || !at_head_ff) ? LINK_NULL : cur_head;
               id_we        = 1'b1;
               id_wdata     = seq_nx;
               vld_in[cur_ff] = 1'b1;
               free_head_in = link_rd;
               seq_in[port_ff] = seq_nx;
               if (q_empty) begin
                  head_in[port_ff] = LINK_W'(cur_ff);
                  tail_in[port_ff] = LINK_W'(cur_ff);
               end else if (!at_head_ff) begin
                  tail_in[port_ff] = LINK_W'(cur_ff);
               end else begin
                  head_in[port_ff] = LINK_W'(cur_ff);
               end
               fin_rsp.status    = STAT_OK;
               fin_rsp.slot      = SLOT_W'(cur_ff);
               fin_rsp.packet_id = seq_nx;
               state_in          = ST_IDLE;
            end
         end

         ST_DEQ: begin
            if (out_free) begin
               fin          = 1'b1;
               link_we      = 1'b1;
               link_waddr   = cur_ff;
               link_wdata   = free_head_ff;
               id_we        = 1'b1;
               id_wdata     = '0;
               vld_in[cur_ff] = 1'b1;
               free_head_in = LINK_W'(cur_ff);
               if (link_ok(link_rd)) begin
                  head_in[port_ff] = link_rd;
               end else begin
                  head_in[port_ff] = LINK_NULL;
                  tail_in[port_ff] = LINK_NULL;
               end
               fin_rsp.status    = STAT_OK;
               fin_rsp.slot      = SLOT_W'(cur_ff);
               fin_rsp.packet_id = id_rd;
               state_in          = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            // next link already read; recycle this slot, then read the following one or finish
            if (more || out_free) begin
               link_we      = 1'b1;
               link_waddr   = cur_ff;
               link_wdata   = free_head_ff;
               id_we        = 1'b1;
               id_wdata     = '0;
               vld_in[cur_ff] = 1'b1;
               free_head_in = LINK_W'(cur_ff);
               cnt_in       = cnt_nx;
               if (more) begin
                  rd_en      = 1'b1;
                  rd_addr_in = link_rd[SLOT_AW-1:0];
                  cur_in     = link_rd[SLOT_AW-1:0];
               end else begin
                  fin              = 1'b1;
                  head_in[port_ff] = LINK_NULL;
                  tail_in[port_ff] = LINK_NULL;
                  fin_rsp.status   = STAT_OK;
                  state_in         = ST_IDLE;
               end
            end
         end

         ST_DONE: begin
            if (out_free) begin
               fin      = 1'b1;
               fin_rsp  = res_ff;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rd_vld_in    = vld_ff[rd_addr_in];
   assign rsp_valid_in = fin || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = fin ? fin_rsp : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= '0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            head_ff[i] <= LINK_NULL;
            tail_ff[i] <= LINK_NULL;
            seq_ff[i]  <= '0;
         end
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         seq_ff       <= seq_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      port_ff     <= port_in;
      at_head_ff  <= at_head_in;
      cur_ff      <= cur_in;
      cnt_ff      <= cnt_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (rd_en) begin
         rd_addr_ff <= rd_addr_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   // a finished dequeue puts its slot on top of the free list
   a_deq_frees: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEQ && out_free) |=> free_head_ff == LINK_W'($past(cur_ff)))
      else $error("dequeued slot not at free list head");

   // a finished enqueue leaves the port queue non-empty
   a_enq_links: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENQ && out_free) |=>
         (head_ff[port_ff] != LINK_NULL) && (tail_ff[port_ff] != LINK_NULL))
      else $error("enqueue left port queue empty");

   // the flush walk stays within the pool size
   a_flush_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FLUSH |-> cnt_ff < CNT_W'(POOL_SLOTS))
      else $error("flush walk exceeded pool size");

   // a new response word only comes out of a command in progress
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff) != ST_IDLE)
      else $error("response word without a command");

endmodule

// ===== bench/tb_shared_pool_port_queue_manager_unit.sv =====
module tb_shared_pool_port_queue_manager_unit import spqm_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_SLOTS = 16;
   localparam int PORT_COUNT = 4;

   // link value meaning "no slot", one past the last slot index
   localparam logic [4:0] NO_LINK = 5'(POOL_SLOTS);

   // command code the block leaves unused, must come back as a plain ok word
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   // idle mixes: sender idles a lot less than the receiver, then the reverse, then none
   localparam int MIX_SLOW_SINK   = 0;
   localparam int MIX_SLOW_SOURCE = 1;
   localparam int MIX_FULL_RATE   = 2;

   // one pending request word plus how it is to be sent
   typedef struct {
      req_type     word;
      bit          drain_first;
      int unsigned mix;
   } send_entry_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   shared_pool_port_queue_manager_unit #(
      .POOL_SLOTS(POOL_SLOTS),
      .PORT_COUNT(PORT_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   // shadow of the pool: link memory, free list top, per-port queues and ids
   logic [4:0] link_mem [POOL_SLOTS];
   logic [4:0] free_top;
   logic [4:0] port_head [PORT_COUNT];
   logic [4:0] port_tail [PORT_COUNT];
   logic [7:0] port_seq [PORT_COUNT];
   logic [7:0] slot_id [POOL_SLOTS];

   send_entry_type words_to_send [$];
   rsp_type        awaited_replies [$];
   rsp_type        want_reply;

   bit          req_taken = 1'b0;
   int unsigned words_taken = 0;
   int unsigned words_made = 0;
   int unsigned port0_enqueues = 0;
   int unsigned failures = 0;
   int unsigned gap_pct = 13;
   int unsigned stall_pct = 76;
   int unsigned gen_mix = MIX_SLOW_SINK;
   bit          drain_next = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // push a slot back onto the free list and forget its id
   function automatic void free_slot(logic [4:0] s);
      slot_id[s] = '0;
      link_mem[s] = free_top;
      free_top = s;
   endfunction

   // advance the shadow pool by one request word and return the reply it must produce
   function automatic rsp_type track_command(req_type w);
      rsp_type     r;
      logic [4:0]  s;
      logic [4:0]  nx;
      logic [7:0]  seq;
      int unsigned n;
      int unsigned p;
      r = '0;
      r.status = STAT_OK;
      p = w.port;
      if (w.command == CMD_SPARE) begin
         // unused code: no state change, all-zero reply
      end else if (p >= PORT_COUNT) begin
         r.status = STAT_BAD_PORT;
      end else if (w.command == CMD_ENQUEUE) begin
         s = free_top;
         if (s >= POOL_SLOTS) begin
            r.status = STAT_POOL_EMPTY;
         end else begin
            free_top = link_mem[s];
            link_mem[s] = NO_LINK;
            if (port_head[p] >= POOL_SLOTS || port_tail[p] >= POOL_SLOTS) begin
               // empty queue: slot is head and tail, the head flag does not matter
               port_head[p] = s;
               port_tail[p] = s;
            end else if (!w.insert_at_head) begin
               link_mem[port_tail[p]] = s;
               port_tail[p] = s;
            end else begin
               link_mem[s] = port_head[p];
               port_head[p] = s;
            end
            // per-port id skips zero on wrap
            seq = port_seq[p] + 8'd1;
            if (seq == 8'd0) seq = 8'd1;
            port_seq[p] = seq;
            slot_id[s] = seq;
            r.slot = s[3:0];
            r.packet_id = seq;
         end
      end else if (w.command == CMD_DEQUEUE) begin
         s = port_head[p];
         if (s >= POOL_SLOTS) begin
            r.status = STAT_QUEUE_EMPTY;
         end else begin
            nx = link_mem[s];
            r.slot = s[3:0];
            r.packet_id = slot_id[s];
            if (nx < POOL_SLOTS) begin
               port_head[p] = nx;
            end else begin
               port_head[p] = NO_LINK;
               port_tail[p] = NO_LINK;
            end
            free_slot(s);
         end
      end else begin
         // flush: next link is read before the slot goes back to the free list
         s = port_head[p];
         n = 0;
         while (s < POOL_SLOTS && n < POOL_SLOTS) begin
            nx = link_mem[s];
            free_slot(s);
            s = nx;
            n++;
         end
         port_head[p] = NO_LINK;
         port_tail[p] = NO_LINK;
      end
      return r;
   endfunction

   // queue one request word for the driver
   task automatic push_word(logic [CMD_W-1:0] cmd, logic [PORT_W-1:0] port, bit at_head);
      send_entry_type e;
      e.word.command = cmd;
      e.word.port = port;
      e.word.insert_at_head = at_head;
      e.drain_first = drain_next;
      e.mix = gen_mix;
      drain_next = 1'b0;
      words_to_send.push_back(e);
      if (cmd != CMD_SPARE) words_made++;
      if (cmd == CMD_ENQUEUE && port == 0) port0_enqueues++;
   endtask

   // mostly real ports, now and then a port number from the configured count up to 7
   function automatic logic [PORT_W-1:0] pick_port();
      if ($urandom_range(99) < 85) return PORT_W'($urandom_range(PORT_COUNT - 1));
      return PORT_W'($urandom_range(7, PORT_COUNT));
   endfunction

   // driver: new words and ready change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
         // a word still waiting for its handshake is held as it is
         if (!req_valid || req_taken) begin
            if (words_to_send.size() != 0) begin
               case (words_to_send[0].mix)
                  MIX_SLOW_SINK: begin
                     gap_pct = 13;
                     stall_pct = 76;
                  end
                  MIX_SLOW_SOURCE: begin
                     gap_pct = 76;
                     stall_pct = 13;
                  end
                  default: begin
                     gap_pct = 0;
                     stall_pct = 0;
                  end
               endcase
            end
            if (words_to_send.size() == 0 ||
                (words_to_send[0].drain_first && awaited_replies.size() != 0) ||
                $urandom_range(99) < gap_pct) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= words_to_send[0].word;
               void'(words_to_send.pop_front());
            end
         end
      end
   end

   // monitor: both handshakes seen on the rising edge, replies checked oldest first
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < POOL_SLOTS; i++) begin
            link_mem[i] = 5'(i + 1);
            slot_id[i] = '0;
         end
         link_mem[POOL_SLOTS - 1] = NO_LINK;
         free_top = '0;
         for (int i = 0; i < PORT_COUNT; i++) begin
            port_head[i] = NO_LINK;
            port_tail[i] = NO_LINK;
            port_seq[i] = '0;
         end
         req_taken = 1'b0;
      end else begin
         // reply first, so a word taken on this edge cannot match its own reply
         if (rsp_valid && rsp_ready) begin
            if (awaited_replies.size() == 0) begin
               $error("reply word with nothing awaited: %p", rsp_data);
               failures++;
            end else begin
               want_reply = awaited_replies.pop_front();
               if (rsp_data.status !== want_reply.status) begin
                  $error("status expected %0d actual %0d", want_reply.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.slot !== want_reply.slot) begin
                  $error("slot expected %0d actual %0d", want_reply.slot, rsp_data.slot);
                  failures++;
               end
               if (rsp_data.packet_id !== want_reply.packet_id) begin
                  $error("packet_id expected %0d actual %0d",
                         want_reply.packet_id, rsp_data.packet_id);
                  failures++;
               end
            end
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            awaited_replies.push_back(track_command(req_data));
            words_taken++;
         end
      end
   end

   initial begin : stimulus
      int unsigned    pick;
      int unsigned    count;
      int unsigned    total;
      int unsigned    next_mix;
      logic [PORT_W-1:0] port;

      // directed: empty cases, bad ports, unused code, head/tail links, full pool
      push_word(CMD_DEQUEUE, 3'd0, 1'b0);   // dequeue from empty queue
      push_word(CMD_FLUSH, 3'd1, 1'b1);     // flush of empty queue
      push_word(CMD_SPARE, 3'd7, 1'b1);     // unused code on a bad port still a no-op
      push_word(CMD_ENQUEUE, 3'd4, 1'b1);   // bad port
      push_word(CMD_FLUSH, 3'd7, 1'b0);     // bad port
      push_word(CMD_ENQUEUE, 3'd0, 1'b1);   // head flag into empty queue
      push_word(CMD_ENQUEUE, 3'd0, 1'b0);   // append at tail
      push_word(CMD_ENQUEUE, 3'd0, 1'b1);   // head insert, tail unchanged
      for (int i = 0; i < POOL_SLOTS - 3; i++) push_word(CMD_ENQUEUE, 3'd3, i[0]);
      push_word(CMD_ENQUEUE, 3'd2, 1'b0);   // pool exhausted
      push_word(CMD_DEQUEUE, 3'd0, 1'b0);
      push_word(CMD_FLUSH, 3'd3, 1'b1);     // long walk
      push_word(CMD_DEQUEUE, 3'd0, 1'b1);
      push_word(CMD_DEQUEUE, 3'd0, 1'b0);   // last slot, head and tail go null

      // random bursts; keep going until port 0 ids have wrapped past 255
      drain_next = 1'b1;
      while (words_made < 825 || port0_enqueues < 340) begin
         next_mix = (words_made < 300) ? MIX_SLOW_SINK :
                    (words_made < 567) ? MIX_SLOW_SOURCE : MIX_FULL_RATE;
         if (next_mix != gen_mix || $urandom_range(99) < 3) drain_next = 1'b1;
         gen_mix = next_mix;
         pick = $urandom_range(99);
         if (pick < 45) begin
            // churn on port 0: enqueue/dequeue pairs, sometimes clear another port first
            if ($urandom_range(1)) push_word(CMD_FLUSH, PORT_W'($urandom_range(3, 1)),
                                             1'($urandom_range(1)));
            count = $urandom_range(20, 8);
            for (int i = 0; i < count; i++) begin
               push_word(CMD_ENQUEUE, 3'd0, 1'($urandom_range(1)));
               push_word(CMD_DEQUEUE, 3'd0, 1'($urandom_range(1)));
            end
         end else if (pick < 65) begin
            // fill a port, can run the pool dry, then drain it part way or flush it
            port = pick_port();
            total = $urandom_range(18, 1);
            for (int i = 0; i < total; i++) push_word(CMD_ENQUEUE, port, 1'($urandom_range(1)));
            if ($urandom_range(1)) begin
               push_word(CMD_FLUSH, port, 1'($urandom_range(1)));
            end else begin
               count = $urandom_range(total);
               for (int i = 0; i < count; i++) push_word(CMD_DEQUEUE, port, 1'($urandom_range(1)));
            end
         end else if (pick < 90) begin
            // noise: any code, any port
            count = $urandom_range(8, 1);
            for (int i = 0; i < count; i++)
               push_word(CMD_W'($urandom_range(3)), PORT_W'($urandom_range(7)),
                         1'($urandom_range(1)));
         end else begin
            // dequeue from a port, can run past empty, then maybe flush one
            port = pick_port();
            count = $urandom_range(6, 1);
            for (int i = 0; i < count; i++) push_word(CMD_DEQUEUE, port, 1'($urandom_range(1)));
            if ($urandom_range(1)) push_word(CMD_FLUSH, pick_port(), 1'($urandom_range(1)));
         end
      end
      total = words_to_send.size();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every word taken and every reply back, then room for a full flush walk
      while (words_taken != total || awaited_replies.size() != 0) @(negedge clock);
      repeat (3 * POOL_SLOTS) @(posedge clock);

      if (failures == 0 && awaited_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
